>>> hw/rtl/cmf_pkg.sv
// Shared types and constants for the cross median filter.
// Used by cmf_front, cmf_fifo, cmf_back and the core; depends on nothing.
package cmf_pkg;

  localparam int MaxWidthDefault  = 2048;
  localparam int PixelBitsDefault = 8;
  localparam int ImageWidthBits   = 12;
  localparam int ImageHeightBits  = 16;
  localparam int FifoDepth        = 4;

  localparam logic [ImageWidthBits-1:0]  ImageWidthReset  = 12'd640;
  localparam logic [ImageHeightBits-1:0] ImageHeightReset = 16'd400;

  typedef enum logic {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ImageWidthBits-1:0]  image_width;
    logic [ImageHeightBits-1:0] image_height;
  } cfg_t;

endpackage

>>> hw/rtl/cmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds read data while the read enable is low.
module cmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cmf_front.sv
// Front end: accepts beats, tracks row and column, owns the line store (one
// RAM, two rows per word), builds median jobs. Depends on cmf_pkg and cmf_ram.
module cmf_front #(
  parameter int MAX_WIDTH  = cmf_pkg::MaxWidthDefault,
  parameter int PIXEL_BITS = cmf_pkg::PixelBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cmf_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_flush_i,
  input  logic [PIXEL_BITS-1:0]                in_pixel_i,
  input  logic [$clog2(cmf_pkg::FifoDepth+1)-1:0] fifo_count_i,
  output logic                                 push_o,
  output logic [5*PIXEL_BITS:0]                push_data_o
);

  import cmf_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = XW + 1;
  localparam int PB = PIXEL_BITS;
  localparam int RW = 2 * PIXEL_BITS;
  localparam int HW = ImageHeightBits;

  logic [XW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic          flush_q, flush_d;
  logic [PB-1:0] lastc_q;
  logic          byp_valid_q;
  logic [RW-1:0] byp_data_q;
  logic          s1_valid_q;
  logic [PB-1:0] s1_c_q, s1_up_q, s1_dn_q, s1_left_q;
  logic          s1_use_right_q, s1_last_q;

  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] col_inc;
  logic [HW:0]   row_inc;
  logic          row_end, frame_end;
  logic [XW-1:0] next_col;
  logic          accept, do_pix, do_flush, emit, has_up;
  logic [RW-1:0] ram_rdata, rd_eff, wdata;
  logic [PB-1:0] cur_c, cur_above, up, dn, left, right;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_i.image_width) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_i.image_width);
    end
    eff_h = (cfg_i.image_height == '0) ? HW'(1) : cfg_i.image_height;
  end

  assign in_ready_o = (32'(fifo_count_i) + 32'(s1_valid_q)) < 32'(FifoDepth);
  assign accept     = in_valid_i && in_ready_o;
  assign do_pix     = accept && !in_flush_i && !flush_q;
  assign do_flush   = accept && in_flush_i && flush_q;

  assign col_inc   = {1'b0, col_q} + CW'(1);
  assign row_end   = col_inc >= eff_w;
  assign next_col  = row_end ? '0 : col_inc[XW-1:0];
  assign row_inc   = {1'b0, row_q} + (HW+1)'(1);
  assign frame_end = row_inc >= {1'b0, eff_h};

  assign rd_eff    = byp_valid_q ? byp_data_q : ram_rdata;
  assign cur_c     = rd_eff[PB-1:0];
  assign cur_above = rd_eff[RW-1:PB];

  assign emit   = (do_pix && (row_q != '0)) || do_flush;
  assign has_up = do_pix ? (row_q >= HW'(2)) : (row_q != '0);
  assign up     = has_up ? cur_above : cur_c;
  assign dn     = do_pix ? in_pixel_i : cur_c;
  assign left   = (col_q != '0) ? lastc_q : cur_c;
  assign wdata  = {cur_c, in_pixel_i};

  cmf_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (do_pix),
    .waddr_i (col_q),
    .wdata_i (wdata),
    .re_i    (do_pix || do_flush),
    .raddr_i (next_col),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (do_pix) begin
      col_d = next_col;
      if (row_end) begin
        if (frame_end) begin
          flush_d = 1'b1;
        end else begin
          row_d = row_inc[HW-1:0];
        end
      end
    end else if (do_flush) begin
      col_d = next_col;
      if (row_end) begin
        row_d   = '0;
        flush_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      flush_q     <= 1'b0;
      lastc_q     <= '0;
      byp_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      flush_q    <= flush_d;
      s1_valid_q <= emit;
      if (emit) begin
        lastc_q <= cur_c;
      end
      if (do_pix || do_flush) begin
        byp_valid_q <= do_pix && (next_col == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pix || do_flush) begin
      byp_data_q <= wdata;
    end
    if (emit) begin
      s1_c_q         <= cur_c;
      s1_up_q        <= up;
      s1_dn_q        <= dn;
      s1_left_q      <= left;
      s1_use_right_q <= !row_end;
      s1_last_q      <= do_flush && row_end;
    end
  end

  // Right neighbour arrives from the line store in the cycle after accept.
  assign right       = s1_use_right_q ? rd_eff[PB-1:0] : s1_c_q;
  assign push_o      = s1_valid_q;
  assign push_data_o = {s1_last_q, right, s1_left_q, s1_dn_q, s1_up_q, s1_c_q};

endmodule

>>> hw/rtl/cmf_fifo.sv
// Short job queue between front and back end.
// Depends on cmf_pkg for the default depth.
module cmf_fifo #(
  parameter int WIDTH = 41,
  parameter int DEPTH = cmf_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  import cmf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + NW'(1);
      2'b01:   count_d = count_q - NW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/cmf_back.sv
// Back end: five-input median network and the output register.
// Depends on cmf_pkg for the default pixel width.
module cmf_back #(
  parameter int PIXEL_BITS = cmf_pkg::PixelBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  logic [5*PIXEL_BITS:0] job_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] out_median_o,
  output logic                  out_last_o
);

  import cmf_pkg::*;

  localparam int PB = PIXEL_BITS;

  typedef logic [PB-1:0] pix_t;

  logic out_valid_q;
  pix_t median_q;
  logic last_q;
  pix_t med;

  function automatic pix_t median5(input pix_t a, input pix_t b, input pix_t c,
                                   input pix_t d, input pix_t e);
    pix_t v0, v1, v2, v3, v4, t;
    v0 = a; v1 = b; v2 = c; v3 = d; v4 = e;
    if (v0 > v3) begin t = v0; v0 = v3; v3 = t; end
    if (v1 > v4) begin t = v1; v1 = v4; v4 = t; end
    if (v0 > v2) begin t = v0; v0 = v2; v2 = t; end
    if (v1 > v3) begin t = v1; v1 = v3; v3 = t; end
    if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
    if (v2 > v4) begin t = v2; v2 = v4; v4 = t; end
    if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
    if (v3 > v4) begin t = v3; v3 = v4; v4 = t; end
    if (v2 > v3) begin t = v2; v2 = v3; v3 = t; end
    return v2;
  endfunction

  assign med = median5(job_data_i[PB-1:0], job_data_i[2*PB-1:PB],
                       job_data_i[3*PB-1:2*PB], job_data_i[4*PB-1:3*PB],
                       job_data_i[5*PB-1:4*PB]);

  assign pop_o        = job_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign out_median_o = median_q;
  assign out_last_o   = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      median_q <= med;
      last_q   <= job_data_i[5*PB];
    end
  end

endmodule

>>> hw/rtl/cross_median_filter_core.sv
// Cross median filter: 5-point median of a pixel and its four neighbours.
// Input beats carry a pixel (tuser 0) or a flush tick (tuser 1) in raster
// order; each output beat is one filtered pixel, tlast on the frame's last.
// Output for row r is produced while row r+1 arrives; after the final input
// row, one flush tick per pixel drains it. Pixels of the first row give no
// output. Edge neighbours fall back to the centre value.
// Throughput: one beat per clock in each direction while the receiver accepts
// and the job queue has room; the line store has one write and one read port;
// a pixel beat uses one of each, a flush tick only the read port. Each job is
// registered in stage 1, then passes the job queue and the output register.
// A four-entry job queue separates the front end from the output register;
// when the receiver stalls, s_axis_tready drops once the queue fills.
// Reset clears position counters and queues; line stores keep no reset.
// The APB port holds image_width (0x0) and image_height (0x4); write only
// between beats. Depends on cmf_pkg, cmf_front, cmf_fifo and cmf_back.
module cross_median_filter_core #(
  parameter int MAX_WIDTH  = cmf_pkg::MaxWidthDefault,
  parameter int PIXEL_BITS = cmf_pkg::PixelBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [PIXEL_BITS-1:0] pixel_value, zero padding above
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [PIXEL_BITS-1:0] median_value, zero padding above
  output logic [((PIXEL_BITS+7)/8)*8-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);

  import cmf_pkg::*;

  localparam int TW = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int JW = 5 * PIXEL_BITS + 1;
  localparam int NW = $clog2(FifoDepth + 1);

  cfg_t                  cfg_q;
  logic                  push, pop, job_valid;
  logic [JW-1:0]         push_data, job_data;
  logic [NW-1:0]         fifo_count;
  logic [PIXEL_BITS-1:0] median;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= ImageWidthReset;
      cfg_q.image_height <= ImageHeightReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[2]))
        RegImageWidth:  cfg_q.image_width  <= pwdata[ImageWidthBits-1:0];
        RegImageHeight: cfg_q.image_height <= pwdata[ImageHeightBits-1:0];
        default:        cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      RegImageWidth:  prdata = 32'(cfg_q.image_width);
      RegImageHeight: prdata = 32'(cfg_q.image_height);
      default:        prdata = '0;
    endcase
  end

  cmf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_flush_i   (s_axis_tuser[0]),
    .in_pixel_i   (s_axis_tdata[PIXEL_BITS-1:0]),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  cmf_fifo #(
    .WIDTH (JW),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .data_o      (job_data),
    .count_o     (fifo_count)
  );

  cmf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_data_i   (job_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_median_o (median),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = TW'(median);

endmodule
